[rtl/core/lz_bitstream_decompressor_macros.svh]
// Assertion macros used by the decompressor checker.
`ifndef LZ_BITSTREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_BITSTREAM_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz decompressor check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LZBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lz decompressor check failed");

`endif

[rtl/core/lzbd_pkg.sv]
// Package: types and constants of the LZ bitstream decompressor.
`timescale 1ns / 1ps
package lzbd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int OFF_W = 13;
    localparam int LEN_W = 9;
    localparam logic [6:0] RAW_BASE = 7'd12;
    localparam logic [LEN_W-1:0] LEN_BYTE_BIAS = 9'd8;
    localparam logic [3:0] PACK_BYTES = 4'd8;

    typedef enum logic [4:0] {
        PH_SKIP1   = 5'd0,
        PH_SKIP2   = 5'd1,
        PH_TOP     = 5'd2,
        PH_B2      = 5'd3,
        PH_B3      = 5'd4,
        PH_B4      = 5'd5,
        PH_LENA    = 5'd6,
        PH_LENB    = 5'd7,
        PH_LENC    = 5'd8,
        PH_RAWN    = 5'd9,
        PH_MARK    = 5'd10,
        PH_OFF0    = 5'd11,
        PH_OFF1    = 5'd12,
        PH_OFF2    = 5'd13,
        PH_OFF3    = 5'd14,
        PH_OFF4    = 5'd15,
        PH_OFF5    = 5'd16,
        PH_OFF6    = 5'd17,
        PH_LIT     = 5'd18,
        PH_RAWB    = 5'd19,
        PH_LENBYTE = 5'd20,
        PH_OFFLO   = 5'd21,
        PH_DONE    = 5'd22
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BITS,
        ST_MRD,
        ST_MWR,
        ST_FLUSH
    } ctrl_state_t;

endpackage

[rtl/core/lzbd_if.sv]
// Interfaces: packed-byte request channel and decompressed result channel.
`timescale 1ns / 1ps
interface lzbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       stream_start;

    modport source (output valid, output packed_byte, output stream_start, input ready);
    modport sink (input valid, input packed_byte, input stream_start, output ready);
endinterface

interface lzbd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        finished;
    logic        bad_offset;

    modport source (output valid, output out_bytes, output byte_count, output run_last,
                    output finished, output bad_offset, input ready);
    modport sink (input valid, input out_bytes, input byte_count, input run_last,
                  input finished, input bad_offset, output ready);
endinterface

[rtl/core/lz_bitstream_decompressor.sv]
// Top level: method-2 LZ stream decompressor built around a history memory.
// Flow: a request passes ST_IDLE and ST_DISPATCH, then ST_BITS reads its
//   control bits (up to 8); a match alternates ST_MRD (history read) and
//   ST_MWR (write back) per byte, and ST_FLUSH hands over the last result.
// Throughput: one request at a time; matches are set by the single history
//   port, and a copy waits while the packer is full and the result is held.
// Reset: rst_n clears decoder, counters and the output valid flag at once;
//   the history memory is not cleared and holds garbage until written.
`timescale 1ns / 1ps
module lz_bitstream_decompressor #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    lzbd_in_if.sink            stream,
    lzbd_out_if.source         result
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW+1:0] DEPTH_X = (AW+2)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    // History store: one write port, one registered read port.
    logic [7:0] hist_mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;
    logic       mem_we;
    logic       mem_re;

    ctrl_state_t     state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [31:0]     size_reg;
    logic [7:0]      byte_reg, byte_next;
    logic [7:0]      bitbuf_reg, bitbuf_next;
    logic [3:0]      left_reg, left_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]      ohigh_reg, ohigh_next;
    logic [6:0]      raw_reg, raw_next;
    logic [AW-1:0]   wi_reg, wi_next;
    logic [31:0]     prod_reg, prod_next;

    // Match copy state.
    logic [OFF_W-1:0] off_reg, off_next;
    logic             mbad_reg, mbad_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;

    // Result packer and output register.
    logic [63:0] acc_bytes_reg, acc_bytes_next;
    logic [3:0]  acc_cnt_reg, acc_cnt_next;
    logic        acc_bad_reg, acc_bad_next;
    logic        acc_fin_reg, acc_fin_next;

    logic        ovalid_reg;
    logic [63:0] obytes_reg;
    logic [3:0]  ocnt_reg;
    logic        olast_reg, ofin_reg, obad_reg;

    logic        out_push, out_last, slot_free;
    logic        emit_en, emit_bad, emit_fin;
    logic [7:0]  emit_byte;
    logic        bit_v;
    logic [OFF_W-1:0] off_calc;
    logic [AW+1:0]    src_sum;
    logic [LEN_W-1:0] len_tmp;

    assign stream.ready = (state_reg == ST_IDLE);
    assign slot_free    = !ovalid_reg || result.ready;

    assign result.valid      = ovalid_reg;
    assign result.out_bytes  = obytes_reg;
    assign result.byte_count = ocnt_reg;
    assign result.run_last   = olast_reg;
    assign result.finished   = ofin_reg;
    assign result.bad_offset = obad_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        bitbuf_next    = bitbuf_reg;
        left_next      = left_reg;
        len_next       = len_reg;
        ohigh_next     = ohigh_reg;
        raw_next       = raw_reg;
        wi_next        = wi_reg;
        prod_next      = prod_reg;
        off_next       = off_reg;
        mbad_next      = mbad_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        acc_bytes_next = acc_bytes_reg;
        acc_cnt_next   = acc_cnt_reg;
        acc_bad_next   = acc_bad_reg;
        acc_fin_next   = acc_fin_reg;
        out_push       = 1'b0;
        out_last       = 1'b0;
        emit_en        = 1'b0;
        emit_byte      = byte_reg;
        emit_bad       = 1'b0;
        mem_re         = 1'b0;
        bit_v          = bitbuf_reg[7];
        len_tmp        = '0;
        off_calc       = {1'b0, ohigh_reg, 8'h00} + OFF_W'(byte_reg) + OFF_W'(1);
        src_sum        = {2'b00, wi_reg} + DEPTH_X - (AW+2)'(off_calc);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (stream.valid)
                begin
                    byte_next  = stream.packed_byte;
                    state_next = ST_DISPATCH;
                    // Restart the decoder ahead of this byte.
                    if (stream.stream_start)
                    begin
                        bitbuf_next = '0;
                        left_next   = '0;
                        phase_next  = PH_SKIP1;
                        len_next    = '0;
                        ohigh_next  = '0;
                        raw_next    = '0;
                        wi_next     = '0;
                        prod_next   = '0;
                    end
                end
            end

            ST_DISPATCH:
            begin
                if (phase_reg == PH_DONE || prod_reg >= size_reg)
                begin
                    // Drop the byte: all requested output is out.
                    phase_next = PH_DONE;
                    state_next = ST_IDLE;
                end
                else if (phase_reg < PH_LIT)
                begin
                    bitbuf_next = byte_reg;
                    left_next   = 4'd8;
                    state_next  = ST_BITS;
                end
                else
                begin
                    state_next = ST_BITS;
                    case (phase_reg)
                        PH_LIT:
                        begin
                            phase_next = PH_TOP;
                            emit_en    = 1'b1;
                        end
                        PH_RAWB:
                        begin
                            raw_next   = (raw_reg != '0) ? raw_reg - 7'd1 : raw_reg;
                            phase_next = (raw_next != '0) ? PH_RAWB : PH_TOP;
                            emit_en    = 1'b1;
                        end
                        PH_LENBYTE:
                        begin
                            if (byte_reg == 8'h00)
                                phase_next = PH_MARK;
                            else
                            begin
                                len_next   = LEN_W'(byte_reg) + LEN_BYTE_BIAS;
                                phase_next = PH_OFF0;
                            end
                        end
                        PH_OFFLO:
                        begin
                            off_next   = off_calc;
                            mbad_next  = {19'd0, off_calc} > prod_reg;
                            src_next   = (src_sum >= DEPTH_X) ? AW'(src_sum - DEPTH_X)
                                                              : AW'(src_sum);
                            cnt_next   = len_reg;
                            phase_next = PH_TOP;
                            state_next = ST_MRD;
                        end
                        default: ;
                    endcase
                end
            end

            ST_MRD:
            begin
                if (cnt_reg == '0 || phase_reg == PH_DONE)
                    state_next = ST_BITS;
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_MWR;
                end
            end

            ST_MWR:
            begin
                if (acc_cnt_reg != PACK_BYTES || slot_free)
                begin
                    // Sources ahead of the stream start read as zero.
                    emit_byte  = (prod_reg < {19'd0, off_reg}) ? 8'h00 : rd_data_reg;
                    emit_bad   = mbad_reg;
                    emit_en    = 1'b1;
                    cnt_next   = cnt_reg - LEN_W'(1);
                    src_next   = (src_reg == LAST_IDX) ? '0 : src_reg + AW'(1);
                    state_next = ST_MRD;
                end
            end

            ST_BITS:
            begin
                if (phase_reg < PH_LIT && left_reg != '0)
                begin
                    bitbuf_next = {bitbuf_reg[6:0], 1'b0};
                    left_next   = left_reg - 4'd1;
                    unique case (phase_reg)
                        PH_SKIP1: phase_next = PH_SKIP2;
                        PH_SKIP2: phase_next = PH_TOP;
                        PH_TOP:   phase_next = bit_v ? PH_B2 : PH_LIT;
                        PH_B2:    phase_next = bit_v ? PH_B3 : PH_LENA;
                        PH_LENA:
                        begin
                            len_next   = LEN_W'(bit_v) + LEN_W'(4);
                            phase_next = PH_LENB;
                        end
                        PH_LENB:  phase_next = bit_v ? PH_LENC : PH_OFF0;
                        PH_LENC:
                        begin
                            len_tmp = LEN_W'(bit_v) + {len_reg[LEN_W-2:0], 1'b0} - LEN_W'(2);
                            if (len_tmp == LEN_W'(9))
                            begin
                                len_next   = LEN_W'(1);
                                phase_next = PH_RAWN;
                            end
                            else
                            begin
                                len_next   = len_tmp;
                                phase_next = PH_OFF0;
                            end
                        end
                        PH_RAWN:
                        begin
                            len_tmp = {len_reg[LEN_W-2:0], bit_v};
                            if (len_tmp >= LEN_W'(16))
                            begin
                                raw_next   = {1'b0, len_tmp[3:0], 2'b00} + RAW_BASE;
                                len_next   = '0;
                                phase_next = PH_RAWB;
                            end
                            else
                                len_next = len_tmp;
                        end
                        PH_B3:
                        begin
                            if (bit_v)
                                phase_next = PH_B4;
                            else
                            begin
                                len_next   = LEN_W'(2);
                                ohigh_next = '0;
                                phase_next = PH_OFFLO;
                            end
                        end
                        PH_B4:
                        begin
                            if (bit_v)
                                phase_next = PH_LENBYTE;
                            else
                            begin
                                len_next   = LEN_W'(3);
                                phase_next = PH_OFF0;
                            end
                        end
                        PH_MARK:  phase_next = PH_TOP;
                        PH_OFF0:
                        begin
                            if (bit_v)
                                phase_next = PH_OFF1;
                            else
                            begin
                                ohigh_next = '0;
                                phase_next = PH_OFFLO;
                            end
                        end
                        PH_OFF1:
                        begin
                            ohigh_next = {3'b000, bit_v};
                            phase_next = PH_OFF2;
                        end
                        PH_OFF2:
                        begin
                            if (bit_v)
                                phase_next = PH_OFF3;
                            else
                                phase_next = (ohigh_reg == '0) ? PH_OFF5 : PH_OFFLO;
                        end
                        PH_OFF3:
                        begin
                            ohigh_next = {ohigh_reg[2:0], bit_v} | 4'b0100;
                            phase_next = PH_OFF4;
                        end
                        PH_OFF4:  phase_next = bit_v ? PH_OFFLO : PH_OFF6;
                        PH_OFF5:
                        begin
                            ohigh_next = {3'b000, bit_v} + 4'd2;
                            phase_next = PH_OFFLO;
                        end
                        PH_OFF6:
                        begin
                            ohigh_next = {ohigh_reg[2:0], bit_v};
                            phase_next = PH_OFFLO;
                        end
                        default: ;
                    endcase
                end
                else
                    state_next = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                if (acc_cnt_reg == '0)
                    state_next = ST_IDLE;
                else if (slot_free)
                begin
                    out_push       = 1'b1;
                    out_last       = 1'b1;
                    acc_cnt_next   = '0;
                    acc_bytes_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Append one output byte to the packer and the history.
        emit_fin = ({1'b0, prod_reg} + 33'd1) >= {1'b0, size_reg};
        if (emit_en)
        begin
            if (acc_cnt_reg == PACK_BYTES)
            begin
                out_push       = 1'b1;
                acc_bytes_next = {56'd0, emit_byte};
                acc_cnt_next   = 4'd1;
            end
            else
            begin
                acc_bytes_next = acc_bytes_reg | (64'(emit_byte) << {acc_cnt_reg[2:0], 3'b000});
                acc_cnt_next   = acc_cnt_reg + 4'd1;
            end
            acc_bad_next = emit_bad;
            acc_fin_next = emit_fin;
            wi_next      = (wi_reg == LAST_IDX) ? '0 : wi_reg + AW'(1);
            prod_next    = prod_reg + 32'd1;
            if (emit_fin)
                phase_next = PH_DONE;
        end
    end

    assign mem_we = emit_en;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[wi_reg] <= emit_byte;
        if (mem_re)
            rd_data_reg <= hist_mem[src_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SKIP1;
            size_reg      <= '0;
            bitbuf_reg    <= '0;
            left_reg      <= '0;
            len_reg       <= '0;
            ohigh_reg     <= '0;
            raw_reg       <= '0;
            wi_reg        <= '0;
            prod_reg      <= '0;
            cnt_reg       <= '0;
            acc_bytes_reg <= '0;
            acc_cnt_reg   <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            bitbuf_reg    <= bitbuf_next;
            left_reg      <= left_next;
            len_reg       <= len_next;
            ohigh_reg     <= ohigh_next;
            raw_reg       <= raw_next;
            wi_reg        <= wi_next;
            prod_reg      <= prod_next;
            cnt_reg       <= cnt_next;
            acc_bytes_reg <= acc_bytes_next;
            acc_cnt_reg   <= acc_cnt_next;
            if (out_push)
                ovalid_reg <= 1'b1;
            else if (result.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        off_reg      <= off_next;
        mbad_reg     <= mbad_next;
        src_reg      <= src_next;
        acc_bad_reg  <= acc_bad_next;
        acc_fin_reg  <= acc_fin_next;
        if (out_push)
        begin
            obytes_reg <= acc_bytes_reg;
            ocnt_reg   <= acc_cnt_reg;
            olast_reg  <= out_last;
            ofin_reg   <= acc_fin_reg;
            obad_reg   <= acc_bad_reg;
        end
    end

endmodule

[rtl/core/lzbd_checker.sv]
// Checker: port-level properties of the decompressor, bound to the top level.
`timescale 1ns / 1ps
`include "lz_bitstream_decompressor_macros.svh"
module lzbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_bytes,
    input logic [3:0]  byte_count,
    input logic        run_last
);
    // Stalled result holds its packing.
    `LZBD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_bytes))
    // Packed count stays in one to eight bytes.
    `LZBD_ASSERT_IMP(a_count, out_valid, byte_count != 4'd0 && byte_count <= 4'd8)
    // Only the closing result of a request may be partly filled.
    `LZBD_ASSERT_IMP(a_full, out_valid && !run_last, byte_count == 4'd8)
    // Unused high bytes read as zero.
    `LZBD_ASSERT_IMP(a_zero, out_valid, (out_bytes >> {byte_count, 3'b000}) == 64'd0)
endmodule

bind lz_bitstream_decompressor lzbd_checker u_lzbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_bytes  (result.out_bytes),
    .byte_count (result.byte_count),
    .run_last   (result.run_last)
);

[test/testbench.sv]
// Testbench for lz_bitstream_decompressor: encoded streams, scoreboard and result checks.
`timescale 1ns / 1ps
module testbench;
    import lzbd_pkg::*;

    // Drain wait after the last expected result: longest match plus the control-bit walk.
    localparam int DRAIN_CYCLES = 700;
    // Hard stop for a hung run.
    localparam int CYCLE_LIMIT  = 4000000;
    // Results that one request can cause at most.
    localparam int MAX_RESULTS  = 33;
    localparam int HIST_DEPTH   = 4096;

    typedef struct {
        logic [63:0] data;
        int          count;
        logic        last;
        logic        finished;
        logic        bad;
    } unpacked_result_t;

    // Scoreboard: a bit-exact decoder mirror plus the queue of results still owed.
    class lz_scoreboard;
        unpacked_result_t owed[$];
        unpacked_result_t step_out[$];
        int unsigned      out_size;
        logic [7:0]       bit_buf;
        int               bits_left;
        phase_t           phase;
        int               run_len;
        int               off_high;
        int               raw_left;
        logic [7:0]       hist[HIST_DEPTH];
        logic [11:0]      wr_ptr;
        int unsigned      produced;
        int               errors;
        int               checked;

        function new();
            out_size = 0;
            errors = 0;
            checked = 0;
            clear_decoder();
        endfunction

        function void clear_decoder();
            bit_buf = 0;
            bits_left = 0;
            phase = PH_SKIP1;
            run_len = 0;
            off_high = 0;
            raw_left = 0;
            wr_ptr = 0;
            produced = 0;
        endfunction

        function void set_size(int unsigned v);
            out_size = v;
        endfunction

        // Append one output byte to the packed results of this request.
        function void put_byte(logic [7:0] b, logic bad);
            unpacked_result_t r;
            if (produced >= out_size)
            begin
                phase = PH_DONE;
                return;
            end
            if (step_out.size() == 0 || step_out[step_out.size() - 1].count >= 8)
            begin
                if (step_out.size() >= MAX_RESULTS)
                    return;
                r.data = 0;
                r.count = 0;
                r.last = 0;
                r.finished = 0;
                r.bad = bad;
                step_out.push_back(r);
            end
            r = step_out[step_out.size() - 1];
            r.data |= 64'(b) << (8 * r.count);
            r.count++;
            hist[wr_ptr] = b;
            wr_ptr = wr_ptr + 12'd1;
            produced++;
            r.finished = (produced >= out_size);
            if (produced >= out_size)
                phase = PH_DONE;
            step_out[step_out.size() - 1] = r;
        endfunction

        function void decode_bit(int b);
            case (phase)
                PH_SKIP1: phase = PH_SKIP2;
                PH_SKIP2: phase = PH_TOP;
                PH_TOP:   phase = b ? PH_B2 : PH_LIT;
                PH_B2:    phase = b ? PH_B3 : PH_LENA;
                PH_LENA:
                begin
                    run_len = b + 4;
                    phase = PH_LENB;
                end
                PH_LENB:  phase = b ? PH_LENC : PH_OFF0;
                PH_LENC:
                begin
                    run_len = b + 2 * run_len - 2;
                    if (run_len == 9)
                    begin
                        run_len = 1;
                        phase = PH_RAWN;
                    end
                    else
                        phase = PH_OFF0;
                end
                PH_RAWN:
                begin
                    run_len = (run_len << 1) | b;
                    if (run_len >= 16)
                    begin
                        raw_left = (run_len & 15) * 4 + 12;
                        run_len = 0;
                        phase = PH_RAWB;
                    end
                end
                PH_B3:
                begin
                    if (b)
                        phase = PH_B4;
                    else
                    begin
                        run_len = 2;
                        off_high = 0;
                        phase = PH_OFFLO;
                    end
                end
                PH_B4:
                begin
                    if (b)
                        phase = PH_LENBYTE;
                    else
                    begin
                        run_len = 3;
                        phase = PH_OFF0;
                    end
                end
                PH_MARK:  phase = PH_TOP;
                PH_OFF0:
                begin
                    if (b)
                        phase = PH_OFF1;
                    else
                    begin
                        off_high = 0;
                        phase = PH_OFFLO;
                    end
                end
                PH_OFF1:
                begin
                    off_high = b;
                    phase = PH_OFF2;
                end
                PH_OFF2:
                begin
                    if (b)
                        phase = PH_OFF3;
                    else
                        phase = (off_high == 0) ? PH_OFF5 : PH_OFFLO;
                end
                PH_OFF3:
                begin
                    off_high = ((2 * off_high + b) | 4) & 15;
                    phase = PH_OFF4;
                end
                PH_OFF4:  phase = b ? PH_OFFLO : PH_OFF6;
                PH_OFF5:
                begin
                    off_high = b + 2;
                    phase = PH_OFFLO;
                end
                PH_OFF6:
                begin
                    off_high = (2 * off_high + b) & 15;
                    phase = PH_OFFLO;
                end
                default: ;
            endcase
        endfunction

        function void decode_data(logic [7:0] b);
            int unsigned span;
            logic        bad;
            logic [7:0]  src;
            case (phase)
                PH_LIT:
                begin
                    phase = PH_TOP;
                    put_byte(b, 1'b0);
                end
                PH_RAWB:
                begin
                    if (raw_left > 0)
                        raw_left--;
                    phase = (raw_left != 0) ? PH_RAWB : PH_TOP;
                    put_byte(b, 1'b0);
                end
                PH_LENBYTE:
                begin
                    if (b == 0)
                        phase = PH_MARK;
                    else
                    begin
                        run_len = b + 8;
                        phase = PH_OFF0;
                    end
                end
                PH_OFFLO:
                begin
                    span = (off_high & 15) * 256 + b + 1;
                    bad = (span > produced);
                    phase = PH_TOP;
                    for (int k = 0; k < run_len && phase != PH_DONE; k++)
                    begin
                        // Sources before the start of the stream read as zero.
                        src = (produced < span) ? 8'h00 : hist[wr_ptr - 12'(span)];
                        put_byte(src, bad);
                    end
                end
                default: ;
            endcase
        endfunction

        // Note an accepted request and queue the results it causes.
        function void note_request(logic [7:0] b, logic start);
            step_out.delete();
            if (start)
                clear_decoder();
            if (phase == PH_DONE || produced >= out_size)
            begin
                phase = PH_DONE;
                return;
            end
            if (phase < PH_LIT)
            begin
                bit_buf = b;
                bits_left = 8;
            end
            else
                decode_data(b);
            while (phase < PH_LIT && bits_left > 0)
            begin
                decode_bit(int'(bit_buf[7]));
                bit_buf = bit_buf << 1;
                bits_left--;
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                owed.push_back(step_out[i]);
        endfunction

        function void check_result(logic [63:0] data, logic [3:0] count, logic last,
                                   logic fin, logic bad);
            unpacked_result_t e;
            checked++;
            if (owed.size() == 0)
            begin
                $error("unexpected result: out_bytes=%h byte_count=%0d", data, count);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (data !== e.data)
            begin
                $error("out_bytes: expected %h, actual %h", e.data, data);
                errors++;
            end
            if (count !== 4'(e.count))
            begin
                $error("byte_count: expected %0d, actual %0d", e.count, count);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("run_last: expected %0b, actual %0b", e.last, last);
                errors++;
            end
            if (fin !== e.finished)
            begin
                $error("finished: expected %0b, actual %0b", e.finished, fin);
                errors++;
            end
            if (bad !== e.bad)
            begin
                $error("bad_offset: expected %0b, actual %0b", e.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    lzbd_in_if  req_if();
    lzbd_out_if res_if();

    lz_bitstream_decompressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (req_if),
        .result    (res_if)
    );

    lz_scoreboard sb = new();

    // Run state shared by the stimulus and the stall generator.
    bit          quiet;
    int          requests_sent;
    int          streams_sent;
    int          stall_left;
    longint      cycles;

    // Stream encoder state: the byte list under construction and its open control byte.
    logic [7:0]  enc[$];
    int          enc_slot;
    int          enc_used;
    int          enc_made;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hard timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: stall in random bursts, none once the run turns quiet.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            res_if.ready = 1'b0;
        end
        else
            res_if.ready = 1'b1;
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.out_bytes, res_if.byte_count, res_if.run_last,
                            res_if.finished, res_if.bad_offset);
    end

    // ---- stream encoder ----------------------------------------------------

    // Control bits go MSB-first into the open control byte; open a new one when full.
    task automatic put_bit(int b);
        if (enc_used == 8)
        begin
            enc.push_back(8'h00);
            enc_slot = enc.size() - 1;
            enc_used = 0;
        end
        enc[enc_slot][7 - enc_used] = b[0];
        enc_used++;
    endtask

    task automatic begin_stream();
        enc.delete();
        enc_used = 8;
        enc_made = 0;
        // The decoder drops the first two bits.
        put_bit($urandom_range(0, 1));
        put_bit($urandom_range(0, 1));
    endtask

    task automatic put_literal(logic [7:0] v);
        put_bit(0);
        enc.push_back(v);
        enc_made++;
    endtask

    // Offset code: high nibble through the variable-length tree, then the low byte.
    task automatic put_offset(int dist_back);
        int h;
        h = ((dist_back - 1) >> 8) & 15;
        if (h == 0)
            put_bit(0);
        else if (h == 1)
        begin
            put_bit(1);
            put_bit(1);
            put_bit(0);
        end
        else if (h < 4)
        begin
            put_bit(1);
            put_bit(0);
            put_bit(0);
            put_bit(h - 2);
        end
        else if (h < 8)
        begin
            put_bit(1);
            put_bit((h >> 1) & 1);
            put_bit(1);
            put_bit(h & 1);
            put_bit(1);
        end
        else
        begin
            put_bit(1);
            put_bit((h >> 2) & 1);
            put_bit(1);
            put_bit((h >> 1) & 1);
            put_bit(0);
            put_bit(h & 1);
        end
        enc.push_back(8'((dist_back - 1) & 255));
    endtask

    // Copy of len bytes from dist_back back; len 2 takes a one-byte offset only.
    task automatic put_match(int len, int dist_back);
        put_bit(1);
        if (len == 2)
        begin
            put_bit(1);
            put_bit(0);
            enc.push_back(8'((dist_back - 1) & 255));
        end
        else if (len == 3)
        begin
            put_bit(1);
            put_bit(1);
            put_bit(0);
            put_offset(dist_back);
        end
        else if (len <= 8)
        begin
            put_bit(0);
            case (len)
                4: begin put_bit(0); put_bit(0); end
                5: begin put_bit(1); put_bit(0); end
                6: begin put_bit(0); put_bit(1); put_bit(0); end
                7: begin put_bit(0); put_bit(1); put_bit(1); end
                default: begin put_bit(1); put_bit(1); put_bit(0); end
            endcase
            put_offset(dist_back);
        end
        else
        begin
            put_bit(1);
            put_bit(1);
            put_bit(1);
            enc.push_back(8'(len - 8));
            put_offset(dist_back);
        end
        enc_made += len;
    endtask

    // Raw run of 12 + 4*n bytes.
    task automatic put_raw(int n);
        put_bit(1);
        put_bit(0);
        put_bit(1);
        put_bit(1);
        put_bit(1);
        for (int i = 3; i >= 0; i--)
            put_bit((n >> i) & 1);
        for (int i = 0; i < 12 + 4 * n; i++)
            enc.push_back(8'($urandom_range(0, 255)));
        enc_made += 12 + 4 * n;
    endtask

    // Zero length byte followed by one ignored bit.
    task automatic put_marker();
        put_bit(1);
        put_bit(1);
        put_bit(1);
        put_bit(1);
        enc.push_back(8'h00);
        put_bit($urandom_range(0, 1));
    endtask

    function automatic int valid_dist();
        int top;
        top = (enc_made > HIST_DEPTH) ? HIST_DEPTH : enc_made;
        return $urandom_range(1, top);
    endfunction

    // Fill the encoder with random tokens until it holds about nbytes bytes.
    task automatic build_random(int nbytes, bit long_copies);
        int pick;
        int len;
        begin_stream();
        while (enc.size() < nbytes)
        begin
            pick = $urandom_range(0, 99);
            if (enc_made == 0 || pick < 38)
                put_literal(8'($urandom_range(0, 255)));
            else if (pick < 75)
            begin
                len = long_copies ? $urandom_range(200, 263) :
                      ($urandom_range(0, 5) == 0 ? $urandom_range(9, 263) : $urandom_range(2, 8));
                put_match(len, (len == 2 && enc_made > 256) ? $urandom_range(1, 256) :
                               valid_dist());
            end
            else if (pick < 83)
            begin
                // Offset past the bytes produced so far, or the largest offset the code allows.
                len = $urandom_range(2, 12);
                if (len == 2 || enc_made >= HIST_DEPTH)
                    put_match(len, (len == 2) ? 256 : HIST_DEPTH);
                else
                    put_match(len, $urandom_range(enc_made + 1, HIST_DEPTH));
            end
            else if (pick < 93)
                put_raw($urandom_range(0, 15));
            else if (pick < 97)
                put_marker();
            else
                enc.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ---- drivers -----------------------------------------------------------

    task automatic write_size(int unsigned v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(posedge clk);
        sb.set_size(v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold until every expected result has come, then, if settle is set, let the block settle.
    task automatic wait_drained(bit settle);
        req_if.valid = 1'b0;
        while (sb.owed.size() != 0)
            @(negedge clk);
        if (settle)
            repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Offer one request and hold it until the handshake completes.
    task automatic send_request(logic [7:0] b, logic start);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.packed_byte = b;
        req_if.stream_start = start;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(b, start);
        requests_sent++;
        @(negedge clk);
    endtask

    // Send the encoded stream; a restart or a pause may be dropped in.
    task automatic send_stream(bit pause_mid, bit noise_restart);
        int cut;
        cut = enc.size() / 2;
        for (int i = 0; i < enc.size(); i++)
        begin
            if (pause_mid && i == cut)
                wait_drained(1'b0);
            send_request(enc[i], (i == 0) || (noise_restart && i == cut));
        end
        streams_sent++;
        req_if.valid = 1'b0;
    endtask

    task automatic run_stream(int unsigned size, int nbytes, bit long_copies,
                              bit pause_mid, bit noise_restart);
        wait_drained(1'b1);
        write_size(size);
        build_random(nbytes, long_copies);
        send_stream(pause_mid, noise_restart);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.packed_byte = '0;
        req_if.stream_start = 1'b0;
        res_if.ready = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        cycles = 0;
        requests_sent = 0;
        streams_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed stream: every code, short and long lengths, a marker, a raw run,
        // a bad offset and a high offset nibble.
        write_size(32'hFFFF_FFFF);
        begin_stream();
        put_literal(8'h00);
        put_literal(8'hFF);
        put_literal(8'hA5);
        put_literal(8'h5A);
        put_match(2, 1);
        put_match(3, 2);
        put_match(4, 3);
        put_match(5, 1);
        put_match(6, 4);
        put_match(7, 5);
        put_match(8, 2);
        put_match(9, 6);
        put_marker();
        put_match(263, 1);
        put_raw(0);
        put_match(4, HIST_DEPTH);
        put_match(5, 300);
        send_stream(1'b0, 1'b0);

        // Output limit extremes: nothing at all, then a single byte.
        run_stream(0, 8, 1'b0, 1'b0, 1'b0);
        run_stream(1, 8, 1'b0, 1'b0, 1'b0);

        // Long copies to wrap the history and reach the full offset range.
        run_stream(32'hFFFF_FFFF, 70, 1'b1, 1'b0, 1'b0);

        // Random streams with clipped and unclipped output sizes.
        for (int s = 0; requests_sent < 330; s++)
        begin
            if (requests_sent > 260)
                quiet = 1'b1;
            run_stream(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 400),
                       $urandom_range(10, 40), 1'b0, s == 2, $urandom_range(0, 7) == 0);
        end

        wait_drained(1'b1);
        if (sb.owed.size() != 0)
            sb.errors++;
        $display("covered %0d requests in %0d streams, %0d results checked",
                 requests_sent, streams_sent, sb.checked);
        $display("streams used every code, markers, raw runs, bad offsets and output clipping");
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
